>>> sv/ps2kbd_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard device side: shared package
// Sizes, request and state codes, command bytes, and the types that pass
// between the step logic, the queues and the output register.
// ----------------------------------------------------------------------------
package ps2kbd_pkg;

    localparam int HALF_BIT_TICKS = 64;
    localparam int SEND_DEPTH     = 16;
    localparam int RECV_DEPTH     = 4;

    localparam int HBC_W   = $clog2(HALF_BIT_TICKS);
    localparam int SEND_AW = $clog2(SEND_DEPTH);
    localparam int SEND_CW = $clog2(SEND_DEPTH + 1);
    localparam int RECV_AW = $clog2(RECV_DEPTH);
    localparam int RECV_CW = $clog2(RECV_DEPTH + 1);

    localparam logic [HBC_W:0]     HBC_SPAN  = (HBC_W + 1)'(HALF_BIT_TICKS);
    localparam logic [SEND_AW:0]   SEND_SPAN = (SEND_AW + 1)'(SEND_DEPTH);
    localparam logic [RECV_AW:0]   RECV_SPAN = (RECV_AW + 1)'(RECV_DEPTH);
    localparam logic [SEND_CW-1:0] SEND_FULL = SEND_CW'(SEND_DEPTH);
    localparam logic [RECV_CW-1:0] RECV_FULL = RECV_CW'(RECV_DEPTH);

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_STATUS = 2'd2;
    localparam logic [1:0] REQ_KEY    = 2'd3;

    localparam logic [1:0] FE_NONE   = 2'd0;
    localparam logic [1:0] FE_START  = 2'd1;
    localparam logic [1:0] FE_STOP   = 2'd2;
    localparam logic [1:0] FE_PARITY = 2'd3;

    localparam logic [4:0] ST_IDLE       = 5'd0;
    localparam logic [4:0] ST_RECV_REQ   = 5'd1;
    localparam logic [4:0] ST_RECV_START = 5'd2;
    localparam logic [4:0] ST_RECV_PAR   = 5'd11;
    localparam logic [4:0] ST_RECV_STOP  = 5'd12;
    localparam logic [4:0] ST_RECV_ACK   = 5'd13;
    localparam logic [4:0] ST_SEND_START = 5'd14;
    localparam logic [4:0] ST_SEND_PAR   = 5'd23;
    localparam logic [4:0] ST_SEND_STOP  = 5'd24;

    localparam logic [7:0] CMD_RESET     = 8'hFF;
    localparam logic [7:0] CMD_ECHO      = 8'hEE;
    localparam logic [7:0] CMD_TYPEMATIC = 8'hF3;
    localparam logic [7:0] BYTE_ACK      = 8'hFA;
    localparam logic [7:0] BYTE_BAT_OK   = 8'hAA;
    localparam logic [7:0] BYTE_BREAK    = 8'hF0;
    localparam logic [7:0] HOST_LINES_RESET = 8'h03;

    typedef struct packed {
        logic [7:0]         host_lines;
        logic [4:0]         link_state;
        logic [HBC_W-1:0]   half_bit_count;
        logic               clock_out;
        logic               data_out;
        logic [7:0]         shift_latch;
        logic               parity_bit;
        logic               irq_pending;
        logic [SEND_AW-1:0] send_head;
        logic [SEND_CW-1:0] send_count;
        logic [RECV_AW-1:0] recv_head;
        logic [RECV_CW-1:0] recv_count;
    } ps2kbd_state_t;

    localparam ps2kbd_state_t STATE_RESET = '{
        host_lines:     HOST_LINES_RESET,
        link_state:     ST_IDLE,
        half_bit_count: '0,
        clock_out:      1'b1,
        data_out:       1'b1,
        shift_latch:    '0,
        parity_bit:     1'b0,
        irq_pending:    1'b0,
        send_head:      '0,
        send_count:     '0,
        recv_head:      '0,
        recv_count:     '0
    };

    typedef struct packed {
        logic               en;
        logic [SEND_AW-1:0] addr;
        logic [7:0]         data;
    } ps2kbd_swr_t;

    typedef struct packed {
        logic               en;
        logic [RECV_AW-1:0] addr;
        logic [7:0]         data;
    } ps2kbd_rwr_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       kbd_clock_line;
        logic       kbd_data_line;
        logic       irq_active;
        logic [1:0] frame_error;
    } ps2kbd_result_t;

    function automatic logic [HBC_W-1:0] hbc_inc(input logic [HBC_W-1:0] v);
        logic [HBC_W:0] t;
        t = {1'b0, v} + 1'b1;
        if (t == HBC_SPAN)
        begin
            t = '0;
        end
        return t[HBC_W-1:0];
    endfunction

    function automatic logic [SEND_AW-1:0] send_wrap(input logic [SEND_AW:0] v);
        logic [SEND_AW:0] t;
        t = (v >= SEND_SPAN) ? v - SEND_SPAN : v;
        return t[SEND_AW-1:0];
    endfunction

    function automatic logic [RECV_AW-1:0] recv_wrap(input logic [RECV_AW:0] v);
        logic [RECV_AW:0] t;
        t = (v >= RECV_SPAN) ? v - RECV_SPAN : v;
        return t[RECV_AW-1:0];
    endfunction

endpackage

>>> sv/ps2_keyboard_device_side.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard device side
// Bit-level device end of a PS/2 keyboard link with host command handling,
// key event queueing and a host status read.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+-----------------------------------------
//   request | req_valid / req_ready  | req_type, write_value, scan_code,
//           |                        | key_release
//   response| rsp_valid / rsp_ready  | read_data, kbd_clock_line, kbd_data_line,
//           |                        | irq_active, frame_error
//
// One request is taken per cycle; its response is valid the next cycle.
// The single output register sets the rate: req_ready is low only while a
// response is held and rsp_ready is low.
// Reset clears the link state and queue pointers at once; queue contents are
// undefined until written.
// ----------------------------------------------------------------------------
module ps2_keyboard_device_side
    import ps2kbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] write_value,
    input  logic [7:0] scan_code,
    input  logic       key_release,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output logic [7:0] read_data,
    output logic       kbd_clock_line,
    output logic       kbd_data_line,
    output logic       irq_active,
    output logic [1:0] frame_error
);

    ps2kbd_state_t  state_reg;
    ps2kbd_state_t  state_next;
    ps2kbd_swr_t    swr_a;
    ps2kbd_swr_t    swr_b;
    ps2kbd_rwr_t    rwr;
    ps2kbd_swr_t    swr_a_gated;
    ps2kbd_swr_t    swr_b_gated;
    ps2kbd_rwr_t    rwr_gated;
    ps2kbd_result_t step_result;
    ps2kbd_result_t rsp_result;
    logic [7:0]     send_head_data;
    logic [7:0]     recv_head_data;
    logic           accept;

    assign accept = req_valid && req_ready;

    always_comb
    begin
        swr_a_gated    = swr_a;
        swr_b_gated    = swr_b;
        rwr_gated      = rwr;
        swr_a_gated.en = swr_a.en && accept;
        swr_b_gated.en = swr_b.en && accept;
        rwr_gated.en   = rwr.en && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    ps2kbd_step u_step (
        .cur            (state_reg),
        .req_type       (req_type),
        .write_value    (write_value),
        .scan_code      (scan_code),
        .key_release    (key_release),
        .send_head_data (send_head_data),
        .recv_head_data (recv_head_data),
        .nxt            (state_next),
        .swr_a          (swr_a),
        .swr_b          (swr_b),
        .rwr            (rwr),
        .result         (step_result)
    );

    ps2kbd_queues u_queues (
        .clk            (clk),
        .swr_a          (swr_a_gated),
        .swr_b          (swr_b_gated),
        .rwr            (rwr_gated),
        .send_head      (state_reg.send_head),
        .recv_head      (state_reg.recv_head),
        .send_head_data (send_head_data),
        .recv_head_data (recv_head_data)
    );

    ps2kbd_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .load_result (step_result),
        .free        (req_ready),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp_result  (rsp_result)
    );

    assign read_data      = rsp_result.read_data;
    assign kbd_clock_line = rsp_result.kbd_clock_line;
    assign kbd_data_line  = rsp_result.kbd_data_line;
    assign irq_active     = rsp_result.irq_active;
    assign frame_error    = rsp_result.frame_error;

endmodule

>>> sv/ps2kbd_queues.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard queues
// Send and receive byte queues in flip-flops, with two send write ports,
// one receive write port and a read of each queue at its head.
// ----------------------------------------------------------------------------
module ps2kbd_queues
    import ps2kbd_pkg::*;
(
    input  logic               clk,
    input  ps2kbd_swr_t        swr_a,
    input  ps2kbd_swr_t        swr_b,
    input  ps2kbd_rwr_t        rwr,
    input  logic [SEND_AW-1:0] send_head,
    input  logic [RECV_AW-1:0] recv_head,
    output logic [7:0]         send_head_data,
    output logic [7:0]         recv_head_data
);

    logic [7:0] send_q_reg [SEND_DEPTH];
    logic [7:0] recv_q_reg [RECV_DEPTH];

    always_ff @(posedge clk)
    begin
        if (swr_a.en)
        begin
            send_q_reg[swr_a.addr] <= swr_a.data;
        end
        if (swr_b.en)
        begin
            send_q_reg[swr_b.addr] <= swr_b.data;
        end
        if (rwr.en)
        begin
            recv_q_reg[rwr.addr] <= rwr.data;
        end
    end

    assign send_head_data = send_q_reg[send_head];
    assign recv_head_data = recv_q_reg[recv_head];

endmodule

>>> sv/ps2kbd_step.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard step logic
// Next state, queue writes and result for one request, from the current
// state and the bytes at the queue heads.
// ----------------------------------------------------------------------------
module ps2kbd_step
    import ps2kbd_pkg::*;
(
    input  ps2kbd_state_t  cur,
    input  logic [1:0]     req_type,
    input  logic [7:0]     write_value,
    input  logic [7:0]     scan_code,
    input  logic           key_release,
    input  logic [7:0]     send_head_data,
    input  logic [7:0]     recv_head_data,
    output ps2kbd_state_t  nxt,
    output ps2kbd_swr_t    swr_a,
    output ps2kbd_swr_t    swr_b,
    output ps2kbd_rwr_t    rwr,
    output ps2kbd_result_t result
);

    ps2kbd_state_t st;
    logic          hd;
    logic          hc;
    logic          inhibit;
    logic          released;
    logic          ticked;
    logic [1:0]    err;
    logic [7:0]    rd;
    logic [7:0]    cmd;

    always_comb
    begin
        st      = cur;
        err     = FE_NONE;
        rd      = '0;
        swr_a   = '0;
        swr_b   = '0;
        rwr     = '0;
        cmd     = recv_head_data;
        ticked  = 1'b0;
        hd       = cur.host_lines[0];
        hc       = cur.host_lines[1];
        inhibit  = hd && !hc;
        released = hd && hc;

        unique case (req_type)
            REQ_TICK:
            begin
                if (inhibit)
                begin
                    st.link_state = ST_IDLE;
                end

                if (st.link_state == ST_IDLE)
                begin
                    if (!st.clock_out)
                    begin
                        if (st.half_bit_count == '0)
                        begin
                            st.clock_out = 1'b1;
                        end
                        st.half_bit_count = hbc_inc(st.half_bit_count);
                    end
                    if (inhibit)
                    begin
                        st.link_state = ST_RECV_REQ;
                    end
                    if (released && st.send_count != '0)
                    begin
                        st.link_state     = ST_SEND_START;
                        st.half_bit_count = '0;
                        st.clock_out      = 1'b0;
                    end
                end
                else if (st.link_state == ST_RECV_REQ)
                begin
                    st.clock_out = 1'b1;
                    if (!hd && hc)
                    begin
                        st.link_state     = ST_RECV_START;
                        st.half_bit_count = '0;
                        st.clock_out      = 1'b0;
                    end
                    if (released && st.send_count != '0)
                    begin
                        st.link_state     = ST_SEND_START;
                        st.half_bit_count = '0;
                        st.clock_out      = 1'b0;
                    end
                end

                if (st.link_state >= ST_RECV_START)
                begin
                    ticked            = (st.half_bit_count == '0);
                    st.half_bit_count = hbc_inc(st.half_bit_count);
                end

                if (ticked)
                begin
                    st.clock_out = !st.clock_out;
                    if (st.clock_out)
                    begin
                        // Rising edge: sample the host's bits.
                        if (st.link_state == ST_RECV_START)
                        begin
                            if (hd)
                            begin
                                err           = FE_START;
                                st.link_state = ST_IDLE;
                            end
                            else
                            begin
                                st.link_state = st.link_state + 5'd1;
                                st.parity_bit = 1'b0;
                            end
                        end
                        else if (st.link_state > ST_RECV_START
                                 && st.link_state < ST_RECV_PAR)
                        begin
                            st.shift_latch = {hd, st.shift_latch[7:1]};
                            st.parity_bit  = st.parity_bit ^ hd;
                            st.link_state  = st.link_state + 5'd1;
                        end
                        else if (st.link_state == ST_RECV_PAR)
                        begin
                            st.parity_bit = st.parity_bit ^ hd;
                            st.link_state = st.link_state + 5'd1;
                        end
                        else if (st.link_state == ST_RECV_STOP)
                        begin
                            if (!hd)
                            begin
                                err           = FE_STOP;
                                st.link_state = ST_IDLE;
                            end
                            else if (!st.parity_bit)
                            begin
                                err           = FE_PARITY;
                                st.link_state = ST_IDLE;
                            end
                            else
                            begin
                                if (st.recv_count < RECV_FULL)
                                begin
                                    rwr.en        = 1'b1;
                                    rwr.addr      = recv_wrap({1'b0, st.recv_head}
                                                    + (RECV_AW + 1)'(st.recv_count));
                                    rwr.data      = st.shift_latch;
                                    st.recv_count = st.recv_count + 1'b1;
                                end
                                st.link_state = st.link_state + 5'd1;
                            end
                        end
                        else if (st.link_state == ST_RECV_ACK)
                        begin
                            st.data_out   = 1'b0;
                            st.link_state = (st.send_count != '0) ? ST_SEND_START
                                                                   : ST_IDLE;
                        end
                    end
                    else
                    begin
                        // Falling edge: drive the next bit to the host.
                        if (st.link_state == ST_SEND_START)
                        begin
                            if (st.send_count == '0)
                            begin
                                st.link_state = ST_IDLE;
                            end
                            else
                            begin
                                st.data_out    = 1'b0;
                                st.shift_latch = send_head_data;
                                st.send_head   = send_wrap({1'b0, st.send_head}
                                                 + (SEND_AW + 1)'(1));
                                st.send_count  = st.send_count - 1'b1;
                                st.parity_bit  = 1'b0;
                                st.link_state  = st.link_state + 5'd1;
                            end
                        end
                        else if (st.link_state > ST_SEND_START
                                 && st.link_state < ST_SEND_PAR)
                        begin
                            st.data_out    = st.shift_latch[0];
                            st.parity_bit  = st.parity_bit ^ st.shift_latch[0];
                            st.shift_latch = {1'b0, st.shift_latch[7:1]};
                            st.link_state  = st.link_state + 5'd1;
                        end
                        else if (st.link_state == ST_SEND_PAR)
                        begin
                            st.data_out   = !st.parity_bit;
                            st.link_state = st.link_state + 5'd1;
                        end
                        else if (st.link_state == ST_SEND_STOP)
                        begin
                            st.data_out   = 1'b1;
                            st.link_state = (st.send_count != '0) ? ST_SEND_START
                                                                   : ST_IDLE;
                        end
                    end
                end

                // A byte received in this same request and written at the head is taken as the command.
                if (rwr.en && rwr.addr == st.recv_head)
                begin
                    cmd = rwr.data;
                end

                if (st.recv_count != '0)
                begin
                    unique case (cmd)
                        CMD_RESET:
                        begin
                            st.recv_head  = recv_wrap({1'b0, st.recv_head}
                                            + (RECV_AW + 1)'(1));
                            st.recv_count = st.recv_count - 1'b1;
                            st.send_head  = '0;
                            st.send_count = SEND_CW'(2);
                            swr_a = '{en: 1'b1, addr: SEND_AW'(0), data: BYTE_ACK};
                            swr_b = '{en: 1'b1, addr: SEND_AW'(1), data: BYTE_BAT_OK};
                        end
                        CMD_ECHO:
                        begin
                            st.recv_head  = recv_wrap({1'b0, st.recv_head}
                                            + (RECV_AW + 1)'(1));
                            st.recv_count = st.recv_count - 1'b1;
                            if (st.send_count < SEND_FULL)
                            begin
                                swr_a.en      = 1'b1;
                                swr_a.addr    = send_wrap({1'b0, st.send_head}
                                                + (SEND_AW + 1)'(st.send_count));
                                swr_a.data    = CMD_ECHO;
                                st.send_count = st.send_count + 1'b1;
                            end
                        end
                        CMD_TYPEMATIC:
                        begin
                            if (st.recv_count >= RECV_CW'(2))
                            begin
                                st.recv_head  = recv_wrap({1'b0, st.recv_head}
                                                + (RECV_AW + 1)'(2));
                                st.recv_count = st.recv_count - RECV_CW'(2);
                                if (st.send_count < SEND_FULL)
                                begin
                                    swr_a.en      = 1'b1;
                                    swr_a.addr    = send_wrap({1'b0, st.send_head}
                                                    + (SEND_AW + 1)'(st.send_count));
                                    swr_a.data    = BYTE_ACK;
                                    st.send_count = st.send_count + 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            st.recv_head  = recv_wrap({1'b0, st.recv_head}
                                            + (RECV_AW + 1)'(1));
                            st.recv_count = st.recv_count - 1'b1;
                        end
                    endcase
                end
            end
            REQ_WRITE:
            begin
                st.host_lines = write_value;
            end
            REQ_STATUS:
            begin
                st.irq_pending = 1'b0;
                rd = {2'b11, st.host_lines[5:2], st.clock_out, st.data_out};
            end
            REQ_KEY:
            begin
                if (key_release && st.send_count < SEND_FULL)
                begin
                    swr_a.en      = 1'b1;
                    swr_a.addr    = send_wrap({1'b0, st.send_head}
                                    + (SEND_AW + 1)'(st.send_count));
                    swr_a.data    = BYTE_BREAK;
                    st.send_count = st.send_count + 1'b1;
                end
                if (st.send_count < SEND_FULL)
                begin
                    swr_b.en      = 1'b1;
                    swr_b.addr    = send_wrap({1'b0, st.send_head}
                                    + (SEND_AW + 1)'(st.send_count));
                    swr_b.data    = scan_code;
                    st.send_count = st.send_count + 1'b1;
                end
                st.irq_pending = 1'b1;
            end
            default:
            begin
                st = cur;
            end
        endcase

        nxt                   = st;
        result.read_data      = rd;
        result.kbd_clock_line = st.clock_out;
        result.kbd_data_line  = st.data_out;
        result.irq_active     = st.irq_pending;
        result.frame_error    = err;
    end

endmodule

>>> sv/ps2kbd_out_reg.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard output register
// Holds one result until the response channel takes it; frees itself in the
// same cycle that it is drained.
// ----------------------------------------------------------------------------
module ps2kbd_out_reg
    import ps2kbd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  ps2kbd_result_t load_result,
    output logic           free,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ps2kbd_result_t rsp_result
);

    logic           valid_reg;
    logic           valid_next;
    ps2kbd_result_t result_reg;

    assign free       = !valid_reg || rsp_ready;
    assign valid_next = load || (valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign rsp_valid  = valid_reg;
    assign rsp_result = result_reg;

endmodule

>>> sv/ps2kbd_checker.sv
// ----------------------------------------------------------------------------
// PS/2 keyboard port checker
// Checks on the top-level ports of the device side, bound to the top level.
// ----------------------------------------------------------------------------
module ps2kbd_checker
    import ps2kbd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic [1:0] req_type,
    input logic [7:0] write_value,
    input logic [7:0] scan_code,
    input logic       key_release,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [7:0] read_data,
    input logic       kbd_clock_line,
    input logic       kbd_data_line,
    input logic       irq_active,
    input logic [1:0] frame_error
);

    logic req_fire;

    assign req_fire = req_valid && req_ready;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data)
            && $stable(frame_error) && $stable(irq_active))
        else $error("Stalled response changed.");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("Request taken while a response is stalled.");

    a_status_read: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req_type == REQ_STATUS |=> rsp_valid && !irq_active
            && read_data[7:6] == 2'b11 && read_data[1] == kbd_clock_line
            && read_data[0] == kbd_data_line)
        else $error("Status read response is wrong.");

    a_key_irq: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req_type == REQ_KEY |=> rsp_valid && irq_active)
        else $error("Key event did not raise the interrupt.");

    a_no_tick_fields: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req_type != REQ_TICK |=> frame_error == FE_NONE
            && (read_data == 8'h00 || $past(req_type) == REQ_STATUS))
        else $error("Non-tick response carries a frame error or read data.");

endmodule

bind ps2_keyboard_device_side ps2kbd_checker u_checker (.*);
